// ===== design/qrr_pkg.sv =====
// shared sizes and status codes for the quadratic real-root solver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qrr_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = 34;
  localparam int STATUS_W   = 2;

  // discriminant magnitude, kept even so the radicand splits into bit pairs
  localparam int DISC_W = 2 * COEF_WIDTH + 2;
  // floor sqrt of disc * 2^(2*FRAC_BITS)
  localparam int ROOT_W = DISC_W / 2 + FRAC_BITS;
  localparam int REM_W  = ROOT_W + 3;
  // magnitude of -b*2^FRAC_BITS +/- root
  localparam int NUM_W  = ROOT_W + 1;
  localparam int NUM_SW = NUM_W + 1;
  // magnitude of 2a
  localparam int DEN_W  = COEF_WIDTH + 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_COMPLEX  = 2'd1,
    ST_NOT_QUAD = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== design/quadratic_real_roots.sv =====
// quadratic real-root solver: discriminant, pipelined square root, two dividers
// depends on qrr_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes a beat (coef_a, coef_b, coef_c) whenever start is high; busy is always
// low, so one beat can enter every clock. Each beat gives exactly one result,
// shown for one cycle with done high; results leave in the order the beats
// came in. The square root takes one root bit per stage (33 stages) and the
// two lockstep restoring dividers one quotient bit per stage (34 stages). The
// receiver cannot stall the block and must take each result in the cycle it is
// shown. status is ok, complex (negative discriminant) or not quadratic (a is
// zero); roots are zero unless status is ok. Roots are signed fixed point with
// FRAC_BITS fraction bits, quotients truncated toward zero.
module quadratic_real_roots
  import qrr_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic signed [COEF_WIDTH-1:0] coef_a,
  input  wire logic signed [COEF_WIDTH-1:0] coef_b,
  input  wire logic signed [COEF_WIDTH-1:0] coef_c,
  output      logic                         done,
  output      logic signed [OUT_W-1:0]      root_plus,
  output      logic signed [OUT_W-1:0]      root_minus,
  output      logic [STATUS_W-1:0]          status
);

  localparam int LATENCY = ROOT_W + NUM_W + 5;
  localparam logic [NUM_W:0] POS_LIM = (NUM_W+1)'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic [NUM_W:0] NEG_LIM = (NUM_W+1)'(64'd1 << (OUT_W - 1));
  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic signed [OUT_W-1:0] OUT_MIN = OUT_W'(64'd1 << (OUT_W - 1));

  // the pipeline never stalls
  assign busy = 1'b0;

  // signed, saturated result from quotient magnitude and sign
  function automatic logic signed [OUT_W-1:0] fix_out(input logic [NUM_W-1:0] q,
                                                      input logic neg);
    logic [NUM_W:0] qx;
    logic [NUM_W:0] qn;
    qx = {1'b0, q};
    qn = -qx;
    if (!neg) begin
      if (qx > POS_LIM) return OUT_MAX;
      return OUT_W'(qx);
    end
    if (qx > NEG_LIM) return OUT_MIN;
    return OUT_W'(qn);
  endfunction

  // stage 1: input registers
  logic                         s1_v;
  logic signed [COEF_WIDTH-1:0] s1_a, s1_b, s1_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start;
    end
    s1_a <= coef_a;
    s1_b <= coef_b;
    s1_c <= coef_c;
  end

  // stage 2: magnitudes and the two products
  logic [COEF_WIDTH-1:0]   ma, mb, mc;
  logic                    s2_v;
  logic [2*COEF_WIDTH-1:0] s2_bb, s2_ac;
  logic                    s2_az, s2_opp;
  logic signed [COEF_WIDTH-1:0] s2_a, s2_b;

  always_comb begin
    ma = s1_a[COEF_WIDTH-1] ? COEF_WIDTH'(-s1_a) : COEF_WIDTH'(s1_a);
    mb = s1_b[COEF_WIDTH-1] ? COEF_WIDTH'(-s1_b) : COEF_WIDTH'(s1_b);
    mc = s1_c[COEF_WIDTH-1] ? COEF_WIDTH'(-s1_c) : COEF_WIDTH'(s1_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_bb  <= mb * mb;
    s2_ac  <= ma * mc;
    s2_az  <= (s1_a == '0);
    // a and c of opposite sign: 4ac term adds
    s2_opp <= (s1_c != '0) && (s1_a[COEF_WIDTH-1] != s1_c[COEF_WIDTH-1]);
    s2_a   <= s1_a;
    s2_b   <= s1_b;
  end

  // stage 3: discriminant and status, feeding the square root
  logic [DISC_W-1:0] bbx, fac;
  logic [DISC_W-1:0] disc_sum, disc_dif;
  status_t           st3;
  logic [DISC_W-1:0] disc3;

  always_comb begin
    bbx      = DISC_W'(s2_bb);
    fac      = DISC_W'(s2_ac) << 2;
    disc_sum = bbx + fac;
    disc_dif = bbx - fac;
    st3      = ST_OK;
    disc3    = '0;
    if (s2_az) begin
      st3 = ST_NOT_QUAD;
    end else if (s2_opp) begin
      disc3 = disc_sum;
    end else if (bbx < fac) begin
      st3 = ST_COMPLEX;
    end else begin
      disc3 = disc_dif;
    end
  end

  // square root pipeline, entry k holds the item after k root bits
  logic                         sq_v    [0:ROOT_W];
  logic [DISC_W-1:0]            sq_rad  [0:ROOT_W];
  logic [REM_W-1:0]             sq_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]            sq_root [0:ROOT_W];
  status_t                      sq_st   [0:ROOT_W];
  logic signed [COEF_WIDTH-1:0] sq_a    [0:ROOT_W];
  logic signed [COEF_WIDTH-1:0] sq_b    [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= s2_v;
    end
    sq_rad[0]  <= disc3;
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
    sq_st[0]   <= st3;
    sq_a[0]    <= s2_a;
    sq_b[0]    <= s2_b;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    always_comb begin
      // next bit pair of the radicand; the low 2*FRAC_BITS bits shift in as zero
      rem_sh = {sq_rem[k][REM_W-3:0], sq_rad[k][DISC_W-1:DISC_W-2]};
      trial  = REM_W'({sq_root[k], 2'b01});
      fits   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else begin
        sq_v[k+1] <= sq_v[k];
      end
      sq_rad[k+1]  <= sq_rad[k] << 2;
      sq_rem[k+1]  <= fits ? rem_sh - trial : rem_sh;
      sq_root[k+1] <= {sq_root[k][ROOT_W-2:0], fits};
      sq_st[k+1]   <= sq_st[k];
      sq_a[k+1]    <= sq_a[k];
      sq_b[k+1]    <= sq_b[k];
    end
  end

  // numerators -b*2^FRAC_BITS +/- root as sign and magnitude
  logic signed [NUM_SW-1:0] nb, rootx, nump, numm;
  logic [COEF_WIDTH-1:0]    amag;

  always_comb begin
    nb    = -(NUM_SW'(sq_b[ROOT_W]) <<< FRAC_BITS);
    rootx = NUM_SW'({2'b00, sq_root[ROOT_W]});
    nump  = nb + rootx;
    numm  = nb - rootx;
    amag  = sq_a[ROOT_W][COEF_WIDTH-1] ? COEF_WIDTH'(-sq_a[ROOT_W])
                                       : COEF_WIDTH'(sq_a[ROOT_W]);
  end

  // divider pipeline, both lanes in lockstep; the numerator register turns
  // into the quotient one bit per stage
  logic              dv_v    [0:NUM_W];
  logic [NUM_W-1:0]  dv_np   [0:NUM_W];
  logic [NUM_W-1:0]  dv_nm   [0:NUM_W];
  logic [DEN_W-1:0]  dv_rp   [0:NUM_W];
  logic [DEN_W-1:0]  dv_rm   [0:NUM_W];
  logic [DEN_W-1:0]  dv_den  [0:NUM_W];
  logic              dv_sp   [0:NUM_W];
  logic              dv_sm   [0:NUM_W];
  status_t           dv_st   [0:NUM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= sq_v[ROOT_W];
    end
    dv_np[0]  <= nump[NUM_SW-1] ? NUM_W'(-nump) : NUM_W'(nump);
    dv_nm[0]  <= numm[NUM_SW-1] ? NUM_W'(-numm) : NUM_W'(numm);
    dv_rp[0]  <= '0;
    dv_rm[0]  <= '0;
    dv_den[0] <= {amag, 1'b0};
    // quotient sign: numerator sign xor sign of 2a
    dv_sp[0]  <= nump[NUM_SW-1] ^ sq_a[ROOT_W][COEF_WIDTH-1];
    dv_sm[0]  <= numm[NUM_SW-1] ^ sq_a[ROOT_W][COEF_WIDTH-1];
    dv_st[0]  <= sq_st[ROOT_W];
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    logic [DEN_W:0] rsp, rsm, dx;
    logic           gp, gm;

    always_comb begin
      rsp = {dv_rp[k], dv_np[k][NUM_W-1]};
      rsm = {dv_rm[k], dv_nm[k][NUM_W-1]};
      dx  = {1'b0, dv_den[k]};
      gp  = (rsp >= dx);
      gm  = (rsm >= dx);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else begin
        dv_v[k+1] <= dv_v[k];
      end
      dv_rp[k+1]  <= gp ? DEN_W'(rsp - dx) : DEN_W'(rsp);
      dv_rm[k+1]  <= gm ? DEN_W'(rsm - dx) : DEN_W'(rsm);
      dv_np[k+1]  <= {dv_np[k][NUM_W-2:0], gp};
      dv_nm[k+1]  <= {dv_nm[k][NUM_W-2:0], gm};
      dv_den[k+1] <= dv_den[k];
      dv_sp[k+1]  <= dv_sp[k];
      dv_sm[k+1]  <= dv_sm[k];
      dv_st[k+1]  <= dv_st[k];
    end
  end

  // output register: sign, saturate, zero unless real roots
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_v[NUM_W];
    end
    status <= dv_st[NUM_W];
    if (dv_st[NUM_W] == ST_OK) begin
      root_plus  <= fix_out(dv_np[NUM_W], dv_sp[NUM_W]);
      root_minus <= fix_out(dv_nm[NUM_W], dv_sm[NUM_W]);
    end else begin
      root_plus  <= '0;
      root_minus <= '0;
    end
  end

  // a beat with a equal to zero comes out as not quadratic after the full latency
  a_not_quad: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && coef_a == '0) |-> ##LATENCY (done && status == ST_NOT_QUAD))
    else $error("a of zero did not give not-quadratic status");

  // roots are zero unless status is ok
  a_zero_roots: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (root_plus == '0 && root_minus == '0))
    else $error("nonzero root with status other than ok");

  // a result always carries one of the three defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_COMPLEX || status == ST_NOT_QUAD))
    else $error("undefined status code");

  // done is the registered valid of the last divider stage
  a_done_track: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(dv_v[NUM_W]))
    else $error("result strobe without a beat in the last divider stage");

endmodule

`default_nettype wire

// ===== tb/sv/qrr_checker.sv =====
// checker for the quadratic real-root solver: predicts each result and compares
// depends on qrr_pkg
`timescale 1ns / 1ps
`default_nettype none

module qrr_checker
  import qrr_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic signed [COEF_WIDTH-1:0] coef_a,
  input  wire logic signed [COEF_WIDTH-1:0] coef_b,
  input  wire logic signed [COEF_WIDTH-1:0] coef_c,
  input  wire logic                         done,
  input  wire logic signed [OUT_W-1:0]      root_plus,
  input  wire logic signed [OUT_W-1:0]      root_minus,
  input  wire logic [STATUS_W-1:0]          status,
  output int                                fail_count,
  output int                                pending
);

  typedef struct packed {
    logic signed [OUT_W-1:0] plus;
    logic signed [OUT_W-1:0] minus;
    status_t                 st;
  } roots_t;

  roots_t roots_due[$];

  function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
    logic [127:0] r;
    logic [127:0] bitv;
    r = 0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(input longint v);
    longint top;
    top = (longint'(1) <<< (OUT_W - 1)) - 1;
    if (v > top) v = top;
    if (v < -top - 1) v = -top - 1;
    return v[OUT_W-1:0];
  endfunction

  function automatic roots_t solve_roots(input longint a, input longint b, input longint c);
    roots_t res;
    longint disc;
    longint r;
    longint nb;
    res = '0;
    if (a == 0) begin
      res.st = ST_NOT_QUAD;
      return res;
    end
    disc = b * b - 4 * a * c;
    if (disc < 0) begin
      res.st = ST_COMPLEX;
      return res;
    end
    r = longint'(floor_sqrt(128'(disc) << (2 * FRAC_BITS)));
    nb = -b * (longint'(1) <<< FRAC_BITS);
    // sv integer division truncates toward zero, as required
    res.plus  = clamp_out((nb + r) / (2 * a));
    res.minus = clamp_out((nb - r) / (2 * a));
    res.st = ST_OK;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    roots_t got;
    roots_t want;
    if (!rst) begin
      if (start && !busy) begin
        roots_due.push_back(solve_roots(longint'(coef_a), longint'(coef_b), longint'(coef_c)));
      end
      if (done) begin
        got.plus = root_plus;
        got.minus = root_minus;
        got.st = status_t'(status);
        if (roots_due.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = roots_due.pop_front();
          if (got.st != want.st)
            report_mismatch($sformatf("status %0d, expected %0d", got.st, want.st));
          if (got.plus != want.plus)
            report_mismatch($sformatf("root_plus %0d, expected %0d", got.plus, want.plus));
          if (got.minus != want.minus)
            report_mismatch($sformatf("root_minus %0d, expected %0d", got.minus, want.minus));
        end
      end
      pending <= roots_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_quadratic_real_roots.sv =====
// testbench top for the quadratic real-root solver: stimulus and verdict
// depends on qrr_pkg, quadratic_real_roots and qrr_checker
`timescale 1ns / 1ps
`default_nettype none

module tb_quadratic_real_roots;
  import qrr_pkg::*;

  // margin to run on after the checker has no results pending
  localparam int DRAIN_CYCLES = 100;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic                         busy;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;
  logic                         done;
  logic signed [OUT_W-1:0]      root_plus;
  logic signed [OUT_W-1:0]      root_minus;
  logic [STATUS_W-1:0]          status;
  int                           fail_count;
  int                           pending;
  int                           beats_sent;

  quadratic_real_roots i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .done(done), .root_plus(root_plus), .root_minus(root_minus), .status(status)
  );

  qrr_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .done(done), .root_plus(root_plus), .root_minus(root_minus), .status(status),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // one coefficient beat: hold start until accepted, then an optional gap
  task automatic send_coefs(input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] c, input int gap);
    start  <= 1'b1;
    coef_a <= a;
    coef_b <= b;
    coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drop_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] small_coef();
    return 16'($signed($urandom_range(0, 40)) - 20);
  endfunction

  initial begin
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] c;
    int gap;
    int burst;
    int wait_cycles;
    rst = 1'b1;
    start = 1'b0;
    coef_a = '0;
    coef_b = '0;
    coef_c = '0;
    beats_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: a zero, complex, double root, field extremes, both signs
    send_coefs(16'd0, 16'd5, 16'd3, 0);           // not quadratic
    send_coefs(16'd0, 16'd0, 16'd0, 0);
    send_coefs(16'd1, 16'd0, 16'd1, 0);           // negative discriminant
    send_coefs(16'd1, 16'd2, 16'd1, 0);           // zero discriminant
    send_coefs(16'd1, -16'sd3, 16'd2, 1);         // roots 1 and 2
    send_coefs(-16'sd1, 16'd0, 16'd4, 0);         // negative a
    send_coefs(16'd2, 16'd0, -16'sd1, 0);         // irrational roots
    send_coefs(16'h8000, 16'h8000, 16'h7fff, 0);  // most negative a and b
    send_coefs(16'h7fff, 16'h7fff, 16'h8000, 0);
    send_coefs(16'h7fff, 16'h8000, 16'h7fff, 0);  // disc b*b - 4ac negative
    send_coefs(16'h8000, 16'h7fff, 16'h8000, 0);
    send_coefs(16'd1, 16'h8000, 16'h8000, 0);     // large roots
    send_coefs(-16'sd1, 16'h7fff, 16'h7fff, 0);
    send_coefs(16'd1, 16'd0, 16'd0, 0);
    send_coefs(16'hffff, 16'hffff, 16'hffff, 0);
    send_coefs(16'h5555, 16'haaaa, 16'h5555, 2);
    send_coefs(16'haaaa, 16'h5555, 16'haaaa, 0);
    send_coefs(16'd3, 16'd1, 16'd0, 0);           // a root at zero
    drop_start();

    // hold off until the pipeline has emptied
    while (pending != 0) @(posedge clk);

    // random: mostly small coefficients so roots are real and exact cases show up,
    // the rest full-range; gaps drawn per beat with bursts of back-to-back beats
    for (int n = 0; n < 1850; n++) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          a = small_coef();
          b = small_coef();
          c = small_coef();
        end
        2: begin
          // wide b and small a, c to keep the discriminant positive
          a = small_coef();
          b = 16'($urandom());
          c = small_coef();
        end
        default: begin
          a = 16'($urandom());
          b = 16'($urandom());
          c = 16'($urandom());
        end
      endcase
      burst = (n / 200) % 2;
      gap = burst ? 0 : $urandom_range(0, 15);
      send_coefs(a, b, c, gap);
    end
    drop_start();

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d coefficient beats sent: directed extremes, a zero, complex,", beats_sent);
    $display("double roots, then random mixed-range beats with random gaps");
    if (fail_count == 0 && pending == 0)
      $display("quadratic_real_roots regression: pass");
    else
      $display("quadratic_real_roots regression: fail");
    $finish;
  end

  initial begin
    #200000;
    $display("quadratic_real_roots regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/qrr_pkg.sv
design/quadratic_real_roots.sv
tb/sv/qrr_checker.sv
tb/sv/tb_quadratic_real_roots.sv
